[src/tmrca_pkg.sv]
// ----------------------------------------------------------------------------
// tmrca_pkg: shared definitions for the tile map renderer
// Sizes, field widths, codes, the controller state type and the
// command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tmrca_pkg;

  // Tile and sheet geometry
  localparam int TILE_W      = 8;
  localparam int TILE_H      = 8;
  localparam int SHEET_WORDS = 65536;  // words per bank, a power of two
  localparam int MAP_DIM     = 512;
  localparam int BANKS       = 2;

  localparam int TILE_PIXELS = TILE_W * TILE_H;
  localparam int ADDR_W      = $clog2(SHEET_WORDS);
  localparam int PX_W        = (TILE_W > 1) ? $clog2(TILE_W) : 1;
  localparam int PY_W        = (TILE_H > 1) ? $clog2(TILE_H) : 1;
  localparam int PIX_W       = (TILE_PIXELS > 1) ? $clog2(TILE_PIXELS) : 1;

  // Field widths
  localparam int KIND_W       = 1;
  localparam int BANK_W       = 1;
  localparam int SHEET_ADDR_W = 16;
  localparam int PIXEL_W      = 32;
  localparam int TILE_NUM_W   = 10;
  localparam int CELL_W       = 9;
  localparam int COORD_W      = 12;
  localparam int GAIN_W       = 12;
  localparam int TPR_W        = 6;
  localparam int CHAN_W       = 8;

  // Tile number division, one quotient bit per step
  localparam int DIV_STEPS = TILE_NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_RED_BLUE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_PER_SHEET_ROW = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd256;
  localparam logic [TPR_W-1:0]  TPR_RESET  = 6'd32;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD   = 1'b0;
  localparam logic [KIND_W-1:0] KIND_RENDER = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ORIGIN,
    ST_RENDER
  } tmrca_state_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [BANK_W-1:0]       sheet_bank;
    logic [SHEET_ADDR_W-1:0] sheet_address;
    logic [PIXEL_W-1:0]      sheet_pixel;
    logic [TILE_NUM_W-1:0]   tile_number;
    logic [CELL_W-1:0]       cell_column;
    logic [CELL_W-1:0]       cell_row;
  } tmrca_item_t;

  typedef struct packed {
    logic            load;       // write the item's word into the sheet
    logic            start;      // latch a render item's fields
    logic            div_step;   // one step of tile number / tiles per row
    logic            origin_en;  // form the tile's top-left word address
    logic            issue;      // read one tile pixel
    logic [PX_W-1:0] px;
    logic [PY_W-1:0] py;
    logic            last;
  } tmrca_cmd_t;

  typedef struct packed {
    logic advance;  // pixel pipeline can take a new read this cycle
  } tmrca_stat_t;

endpackage

[src/tmrca_if.sv]
// ----------------------------------------------------------------------------
// tmrca_if: channel interfaces of the tile map renderer
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface tmrca_item_if
  import tmrca_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [BANK_W-1:0]       sheet_bank;
  logic [SHEET_ADDR_W-1:0] sheet_address;
  logic [PIXEL_W-1:0]      sheet_pixel;
  logic [TILE_NUM_W-1:0]   tile_number;
  logic [CELL_W-1:0]       cell_column;
  logic [CELL_W-1:0]       cell_row;

  modport source (
    output valid, kind, sheet_bank, sheet_address, sheet_pixel,
           tile_number, cell_column, cell_row,
    input  ready
  );
  modport sink (
    input  valid, kind, sheet_bank, sheet_address, sheet_pixel,
           tile_number, cell_column, cell_row,
    output ready
  );
endinterface

interface tmrca_result_if
  import tmrca_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] out_pixel;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic               last_pixel;

  modport source (output valid, out_pixel, out_x, out_y, last_pixel, input ready);
  modport sink   (input valid, out_pixel, out_x, out_y, last_pixel, output ready);
endinterface

interface tmrca_cfg_if
  import tmrca_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/tmrca_ctrl.sv]
// ----------------------------------------------------------------------------
// tmrca_ctrl: item sequencer
// Accepts items; for a render item, steps the tile number division, then
// walks the tile's pixels in row-major order while the pixel pipeline has room.
// ----------------------------------------------------------------------------
module tmrca_ctrl
  import tmrca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [KIND_W-1:0] item_kind,
  output logic              item_ready,
  input  tmrca_stat_t       stat,
  output tmrca_cmd_t        cmd
);

  tmrca_state_t           state;
  tmrca_state_t           state_next;
  logic [DIV_CNT_W-1:0]   div_count;
  logic [PIX_W-1:0]       pixel_step;
  logic                   div_done;
  logic                   pix_last;

  assign div_done = (div_count == DIV_CNT_W'(DIV_STEPS - 1));
  assign pix_last = (pixel_step == PIX_W'(TILE_PIXELS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid && item_kind == KIND_RENDER) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) state_next = ST_ORIGIN;
      end
      ST_ORIGIN: state_next = ST_RENDER;
      ST_RENDER: begin
        if (stat.advance && pix_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready    = 1'b0;
    cmd           = '0;
    cmd.px        = PX_W'(pixel_step % TILE_W);
    cmd.py        = PY_W'(pixel_step / TILE_W);
    cmd.last      = pix_last;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid && (item_kind == KIND_LOAD);
        cmd.start  = item_valid && (item_kind == KIND_RENDER);
      end
      ST_DIVIDE: cmd.div_step  = 1'b1;
      ST_ORIGIN: cmd.origin_en = 1'b1;
      ST_RENDER: cmd.issue     = stat.advance;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      div_count  <= '0;
      pixel_step <= '0;
    end else begin
      state <= state_next;
      if (cmd.start) begin
        div_count <= '0;
      end else if (cmd.div_step) begin
        div_count <= div_count + 1'b1;
      end
      if (cmd.issue) begin
        pixel_step <= pix_last ? '0 : pixel_step + 1'b1;
      end
    end
  end

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && cmd.last) |=> (state == ST_IDLE && pixel_step == '0))
    else $error("sequencer did not return to idle after the last pixel");

  a_divide_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE && div_done) |=> (state == ST_ORIGIN))
    else $error("division did not end after its fixed step count");

  a_issue_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (stat.advance && state == ST_RENDER))
    else $error("pixel read issued without pipeline room");

endmodule

[src/tmrca_datapath.sv]
// ----------------------------------------------------------------------------
// tmrca_datapath: sheet memory, address arithmetic and color pipeline
// Holds the configuration registers and both sheet banks, computes the
// tile origin, reads one pixel per cycle unless the output stalls, and adjusts it into the result.
// ----------------------------------------------------------------------------
module tmrca_datapath
  import tmrca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  tmrca_item_t           item_data,
  input  tmrca_cmd_t            cmd,
  output tmrca_stat_t           stat,
  tmrca_cfg_if.sink             cfg,
  tmrca_result_if.source        result
);

  localparam int STRIDE_W = TPR_W + PX_W;
  localparam int OFF_W    = STRIDE_W + PY_W;
  localparam int ORG_W    = TILE_NUM_W + PIX_W + 1;

  function automatic logic [CHAN_W-1:0] scale_channel(
    input logic [CHAN_W-1:0] ch,
    input logic [GAIN_W-1:0] gain
  );
    logic [CHAN_W+GAIN_W-1:0] prod;
    logic [GAIN_W-1:0]        v;
    prod = (CHAN_W + GAIN_W)'(ch) * (CHAN_W + GAIN_W)'(gain);
    v    = prod[CHAN_W+GAIN_W-1:8];
    return (v > GAIN_W'(8'hFF)) ? 8'hFF : v[CHAN_W-1:0];
  endfunction

  // Configuration
  logic                  swap_red_blue;
  logic [GAIN_W-1:0]     brightness_gain;
  logic [TPR_W-1:0]      tiles_per_sheet_row;
  logic [TPR_W-1:0]      tpr_eff;

  // Render item
  logic [BANK_W-1:0]     bank;
  logic [TILE_NUM_W-1:0] tile_keep;
  logic [TILE_NUM_W-1:0] dividend;
  logic [TPR_W-1:0]      rem;
  logic [TPR_W:0]        trial;
  logic [CELL_W-1:0]     col;
  logic [CELL_W-1:0]     row;
  logic [ADDR_W-1:0]     tile_origin;
  logic [ORG_W-1:0]      origin_sum;
  logic [TILE_NUM_W-1:0] rem_wide;

  // Pixel addressing
  logic [STRIDE_W-1:0]   stride;
  logic [OFF_W-1:0]      row_off;
  logic [ADDR_W-1:0]     rd_addr;

  // Sheet memory, both banks
  logic [PIXEL_W-1:0]    sheet [BANKS*SHEET_WORDS];
  logic [ADDR_W-1:0]     wr_addr;

  // Pipeline
  logic                  advance;
  logic                  s1_valid;
  logic [PIXEL_W-1:0]    rd_data;
  logic [COORD_W-1:0]    s1_x;
  logic [COORD_W-1:0]    s1_y;
  logic                  s1_last;
  logic [CHAN_W-1:0]     ch_a;
  logic [CHAN_W-1:0]     ch_r;
  logic [CHAN_W-1:0]     ch_g;
  logic [CHAN_W-1:0]     ch_b;
  logic                  res_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_red_blue       <= 1'b0;
      brightness_gain     <= GAIN_RESET;
      tiles_per_sheet_row <= TPR_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SWAP_RED_BLUE:       swap_red_blue       <= cfg.data[0];
        CFG_BRIGHTNESS_GAIN:     brightness_gain     <= cfg.data[GAIN_W-1:0];
        CFG_TILES_PER_SHEET_ROW: tiles_per_sheet_row <= cfg.data[TPR_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero tiles per row counts as one
  assign tpr_eff = (tiles_per_sheet_row == '0) ? TPR_W'(1) : tiles_per_sheet_row;

  // Restoring division: only the remainder (sheet column) is kept
  assign trial = {rem, dividend[TILE_NUM_W-1]};

  // Rows above the tile: (tile - column) * TILE_W * TILE_H words
  assign rem_wide   = TILE_NUM_W'(rem);
  assign origin_sum = ORG_W'(TILE_PIXELS) * ORG_W'(tile_keep - rem_wide)
                    + ORG_W'(TILE_W) * ORG_W'(rem_wide);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bank      <= item_data.sheet_bank;
      tile_keep <= item_data.tile_number;
      dividend  <= item_data.tile_number;
      rem       <= '0;
      col       <= CELL_W'(item_data.cell_column % MAP_DIM);
      row       <= CELL_W'(item_data.cell_row % MAP_DIM);
    end else if (cmd.div_step) begin
      dividend <= dividend << 1;
      rem      <= (trial >= {1'b0, tpr_eff}) ? TPR_W'(trial - {1'b0, tpr_eff})
                                             : TPR_W'(trial);
    end
    if (cmd.origin_en) begin
      tile_origin <= ADDR_W'(origin_sum);
    end
  end

  // Addresses wrap within the bank
  assign stride  = STRIDE_W'(tpr_eff) * STRIDE_W'(TILE_W);
  assign row_off = OFF_W'(cmd.py) * OFF_W'(stride);
  assign rd_addr = tile_origin + ADDR_W'(row_off) + ADDR_W'(cmd.px);
  assign wr_addr = ADDR_W'(item_data.sheet_address % SHEET_WORDS);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sheet[{item_data.sheet_bank, wr_addr}] <= item_data.sheet_pixel;
    end
    if (cmd.issue) begin
      rd_data <= sheet[{bank, rd_addr}];
    end
  end

  // Pixel pipeline: read stage, then result register
  assign advance      = !res_valid || result.ready;
  assign stat.advance = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= cmd.issue;
    end
    if (cmd.issue) begin
      s1_x    <= COORD_W'(COORD_W'(col) * COORD_W'(TILE_W) + COORD_W'(cmd.px));
      s1_y    <= COORD_W'(COORD_W'(row) * COORD_W'(TILE_H) + COORD_W'(cmd.py));
      s1_last <= cmd.last;
    end
  end

  assign ch_a = rd_data[31:24];
  assign ch_r = swap_red_blue ? rd_data[7:0] : rd_data[23:16];
  assign ch_g = rd_data[15:8];
  assign ch_b = swap_red_blue ? rd_data[23:16] : rd_data[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      result.out_pixel  <= {ch_a, scale_channel(ch_r, brightness_gain),
                            scale_channel(ch_g, brightness_gain),
                            scale_channel(ch_b, brightness_gain)};
      result.out_x      <= s1_x;
      result.out_y      <= s1_y;
      result.last_pixel <= s1_last;
    end
  end

  assign result.valid = res_valid;

  a_no_load_during_read: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.issue))
    else $error("sheet write and pixel read in the same cycle");

  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |=> s1_valid)
    else $error("issued read did not reach the read stage");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> res_valid)
    else $error("read stage word lost on advance");

endmodule

[src/tile_map_renderer_color_adjust.sv]
// Sequence: a load word is written into the sheet when taken. A render word
//   first divides the tile number, then forms the tile origin, then reads
//   the pixels; each read passes the read stage and the result register.
// Pixels: one per cycle from the single sheet read port while the output
//   is taken; a render word holds the input until its last pixel is read.
// Reset: synchronous; clears the sequencer and pipeline valids and sets the
//   registers to no swap, unity gain and 32 tiles per row. Sheet not cleared.
// ----------------------------------------------------------------------------
// tile_map_renderer_color_adjust: tile map renderer with color adjustment
// Two banks of ARGB32 tile sheets; load words fill them, render words emit
// one tile's pixels with coordinates, optional red/blue swap and gain.
// ----------------------------------------------------------------------------
module tile_map_renderer_color_adjust
  import tmrca_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  tmrca_item_if.sink     item,
  tmrca_result_if.source result,
  tmrca_cfg_if.sink      cfg
);

  tmrca_item_t item_data;
  tmrca_cmd_t  cmd;
  tmrca_stat_t stat;

  // Gather the input word's fields; the datapath samples them only on
  // the load and start commands, both of which mean the word is taken.
  assign item_data = '{
    kind:          item.kind,
    sheet_bank:    item.sheet_bank,
    sheet_address: item.sheet_address,
    sheet_pixel:   item.sheet_pixel,
    tile_number:   item.tile_number,
    cell_column:   item.cell_column,
    cell_row:      item.cell_row
  };

  // Sequencer: takes words only when idle, steps the division, then walks
  // the tile's pixels in row-major order, holding while the output stalls.
  tmrca_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_kind  (item.kind),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: configuration registers, sheet memory, the remainder unit
  // for the sheet column, the address adder, and a two-stage pixel pipe
  // (registered read, then adjusted result register); both stages hold
  // while a finished word waits to be taken.
  tmrca_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item_data (item_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .result    (result)
  );

endmodule
